// ----- rtl/deq_pkg.sv -----
// Shared types for the double-ended queue: operation, status and FSM codes,
// plus the command and neighbor bundle handed to each storage cell.
// No dependencies.
`default_nettype none

package deq_pkg;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_REAR  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_REAR   = 3'd3,
		OP_LIST       = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_LIST = 1'b1
	} state_t;

	typedef enum logic [2:0] {
		CELL_HOLD       = 3'd0,
		CELL_PUSH_FRONT = 3'd1,
		CELL_PUSH_REAR  = 3'd2,
		CELL_POP_FRONT  = 3'd3,
		CELL_POP_REAR   = 3'd4,
		CELL_ROTATE     = 3'd5
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t cmd;
		logic      left_valid;
		logic      right_valid;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/deq_cell.sv -----
// One storage cell of the deque chain: a data word and an occupied bit.
// Depends on deq_pkg for the cell command bundle.
`default_nettype none

module deq_cell #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  deq_pkg::cell_ctrl_t          ctrl,
	input  logic signed [DATA_WIDTH-1:0] word,
	input  logic signed [DATA_WIDTH-1:0] left_data,
	input  logic signed [DATA_WIDTH-1:0] right_data,
	input  logic signed [DATA_WIDTH-1:0] front_data,
	output logic signed [DATA_WIDTH-1:0] data,
	output logic                         valid
);
	import deq_pkg::*;

	logic signed [DATA_WIDTH-1:0] data_q;
	logic                         valid_q;

	// occupied bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			unique case (ctrl.cmd)
				CELL_PUSH_FRONT: valid_q <= ctrl.left_valid;
				CELL_PUSH_REAR:  if (ctrl.left_valid) valid_q <= 1'b1;
				CELL_POP_FRONT:  valid_q <= ctrl.right_valid;
				CELL_POP_REAR:   if (!ctrl.right_valid) valid_q <= 1'b0;
				default:         valid_q <= valid_q;
			endcase
		end
	end

	// data word; no reset
	always_ff @(posedge clk) begin
		unique case (ctrl.cmd)
			CELL_PUSH_FRONT: data_q <= left_data;
			CELL_PUSH_REAR: begin
				if (!valid_q && ctrl.left_valid) data_q <= word;
			end
			CELL_POP_FRONT: data_q <= right_data;
			CELL_ROTATE: begin
				if (valid_q) data_q <= ctrl.right_valid ? right_data : front_data;
			end
			default: data_q <= data_q;
		endcase
	end

	assign data  = data_q;
	assign valid = valid_q;

endmodule

`default_nettype wire

// ----- rtl/double_ended_queue.sv -----
// Double-ended queue over a chain of DEPTH cells, front entry in cell 0.
// Push, pop and list requests give their first result, registered, in the cycle after acceptance.
// Push and pop may be issued back to back (busy stays low).
// List hands out each stored entry in turn (the chain rotates by one cell a cycle);
// busy is high for all but its first cycle.
// Reset clears occupancy, count and FSM at once; results cannot be stalled.
`default_nettype none

module double_ended_queue #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [2:0]                   op,
	input  logic signed [DATA_WIDTH-1:0] item_value,
	output logic                         strobe,
	output logic signed [DATA_WIDTH-1:0] result_value,
	output logic [1:0]                   status,
	output logic                         last_flag
);
	import deq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	state_t                       state_q, state_d;
	logic [CW-1:0]                count_q, count_d;
	logic [CW-1:0]                remain_q, remain_d;
	logic                         accept;
	logic                         empty, full;
	cell_cmd_t                    cmd;

	logic signed [DATA_WIDTH-1:0] cell_data [DEPTH];
	logic [DEPTH-1:0]             cell_valid;
	logic [DEPTH-1:0]             is_rear;
	logic signed [DATA_WIDTH-1:0] rear_data;

	logic                         emit;
	logic signed [DATA_WIDTH-1:0] emit_value;
	status_t                      emit_status;
	logic                         emit_last;

	logic                         strobe_q;
	logic signed [DATA_WIDTH-1:0] value_q;
	status_t                      status_q;
	logic                         last_q;

	// A request is taken only outside a list sweep.
	assign busy   = (state_q == S_LIST);
	assign accept = start && !busy;
	assign empty  = !cell_valid[0];
	assign full   = cell_valid[DEPTH-1];

	// Cell chain: each cell sees its neighbors; cell 0 sees the incoming word
	// on its left, the last cell sees an empty slot on its right.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                         left_v, right_v;
		logic signed [DATA_WIDTH-1:0] left_d, right_d;
		cell_ctrl_t                   ctrl;

		if (i == 0) begin : g_first
			assign left_v = 1'b1;
			assign left_d = item_value;
		end else begin : g_inner_l
			assign left_v = cell_valid[i-1];
			assign left_d = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_v = 1'b0;
			assign right_d = '0;
		end else begin : g_inner_r
			assign right_v = cell_valid[i+1];
			assign right_d = cell_data[i+1];
		end

		assign ctrl.cmd         = cmd;
		assign ctrl.left_valid  = left_v;
		assign ctrl.right_valid = right_v;
		assign is_rear[i]       = cell_valid[i] && !right_v;

		deq_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.word      (item_value),
			.left_data (left_d),
			.right_data(right_d),
			.front_data(cell_data[0]),
			.data      (cell_data[i]),
			.valid     (cell_valid[i])
		);
	end

	// Pick the rear word: exactly one cell is the rear when not empty.
	always_comb begin
		rear_data = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rear_data = rear_data | ({DATA_WIDTH{is_rear[i]}} & cell_data[i]);
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && op == OP_LIST && !empty && count_q != CW'(1)) begin
					state_d = S_LIST;
				end
			end
			S_LIST: begin
				if (remain_q == CW'(1)) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Cell command, count update and result formation
	always_comb begin
		cmd         = CELL_HOLD;
		count_d     = count_q;
		remain_d    = remain_q;
		emit        = 1'b0;
		emit_value  = '0;
		emit_status = ST_OK;
		emit_last   = 1'b1;
		if (state_q == S_LIST) begin
			// hand out the current front and rotate one step
			cmd        = CELL_ROTATE;
			emit       = 1'b1;
			emit_value = cell_data[0];
			emit_last  = (remain_q == CW'(1));
			remain_d   = remain_q - CW'(1);
		end else if (accept) begin
			unique case (op)
				OP_PUSH_FRONT, OP_PUSH_REAR: begin
					emit = 1'b1;
					if (full) begin
						emit_status = ST_OVER;
					end else begin
						cmd     = (op == OP_PUSH_FRONT) ? CELL_PUSH_FRONT : CELL_PUSH_REAR;
						count_d = count_q + CW'(1);
					end
				end
				OP_POP_FRONT, OP_POP_REAR: begin
					emit = 1'b1;
					if (empty) begin
						emit_status = ST_UNDER;
					end else begin
						cmd        = (op == OP_POP_FRONT) ? CELL_POP_FRONT : CELL_POP_REAR;
						emit_value = (op == OP_POP_FRONT) ? cell_data[0] : rear_data;
						count_d    = count_q - CW'(1);
					end
				end
				OP_LIST: begin
					emit = 1'b1;
					if (empty) begin
						emit_status = ST_UNDER;
					end else begin
						// first entry goes out now; the rest during the sweep
						cmd        = CELL_ROTATE;
						emit_value = cell_data[0];
						emit_last  = (count_q == CW'(1));
						remain_d   = count_q - CW'(1);
					end
				end
				default: begin
					// unused codes: drop the request silently
					emit = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			remain_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			remain_q <= remain_d;
			strobe_q <= emit;
		end
	end

	// Result payload; hold when nothing is emitted.
	always_ff @(posedge clk) begin
		if (emit) begin
			value_q  <= emit_value;
			status_q <= emit_status;
			last_q   <= emit_last;
		end
	end

	assign strobe       = strobe_q;
	assign result_value = value_q;
	assign status       = status_q;
	assign last_flag    = last_q;

endmodule

`default_nettype wire

// ----- rtl/deq_chk.sv -----
// Port-level checks for double_ended_queue, attached by bind.
// Depends on deq_pkg for operation and status codes.
`default_nettype none

module deq_chk #(
	parameter int DATA_WIDTH = 32
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic [2:0]                   op,
	input logic signed [DATA_WIDTH-1:0] result_value,
	input logic                         strobe,
	input logic [1:0]                   status,
	input logic                         last_flag
);
	import deq_pkg::*;

	// Every push or pop request gives exactly one final result next cycle.
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (op == OP_PUSH_FRONT || op == OP_PUSH_REAR ||
		 op == OP_POP_FRONT || op == OP_POP_REAR)) |=> (strobe && last_flag))
		else $error("push/pop request did not give one final result");

	// Unused codes produce nothing.
	a_unused_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && op != OP_PUSH_FRONT && op != OP_PUSH_REAR &&
		 op != OP_POP_FRONT && op != OP_POP_REAR && op != OP_LIST) |=> !strobe)
		else $error("unused code produced a result");

	// A list sweep in progress delivers a result every cycle.
	a_sweep_streams: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> strobe)
		else $error("list sweep skipped a cycle");

	// A non-final result means the sweep still holds the queue.
	a_more_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last_flag) |-> busy)
		else $error("non-final result outside a list sweep");

	// Error results are final and carry zero.
	a_error_final: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && status != ST_OK) |-> (last_flag && result_value == '0))
		else $error("error result not final or not zero");

endmodule

bind double_ended_queue deq_chk #(
	.DATA_WIDTH(DATA_WIDTH)
) u_deq_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.op          (op),
	.result_value(result_value),
	.strobe      (strobe),
	.status      (status),
	.last_flag   (last_flag)
);

`default_nettype wire
